// ===== design/s2c_pkg.sv =====
package s2c_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANGLE_START = 3'd0,
		CFG_ANGLE_STEP  = 3'd1,
		CFG_RANGE_LOW   = 3'd2,
		CFG_RANGE_HIGH  = 3'd3
	} cfg_idx_t;

	// pi/2, 30 fraction bits
	localparam logic [30:0] PIH    = 31'd1686629713;
	localparam logic [30:0] FX_ONE = 31'h4000_0000;

	// Horner divisors and floor(2^32 / k)
	localparam int          N_TERMS = 5;
	localparam logic [31:0] DIVS   [N_TERMS] = '{32'd110, 32'd72, 32'd42, 32'd20, 32'd6};
	localparam logic [31:0] RECIPS [N_TERMS] = '{32'd39045157, 32'd59652323, 32'd102261126,
		32'd214748364, 32'd715827882};

	localparam int MAG_W   = 17;
	localparam int SIN_LAT = 4 + 3 * N_TERMS;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== design/s2c_fifo.sv =====
module s2c_fifo #(
	parameter int W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [W-1:0]     push_data,
	input  logic             pop,
	output logic [W-1:0]     pop_data,
	output s2c_pkg::q_stat_t stat
);
	import s2c_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

	assign pop_data   = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

endmodule

// ===== design/s2c_front.sv =====
module s2c_front #(
	parameter int RANGE_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [s2c_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [s2c_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [RANGE_BITS-1:0]               range_value,
	input  logic                                scan_begin,
	input  s2c_pkg::q_stat_t                    q_stat,
	output logic                                push,
	output logic [RANGE_BITS+ANGLE_BITS-1:0]    push_data
);
	import s2c_pkg::*;

	logic [ANGLE_BITS-1:0] angle_start_q;
	logic [ANGLE_BITS-1:0] angle_step_q;
	logic [RANGE_BITS-1:0] range_low_q;
	logic [RANGE_BITS-1:0] range_high_q;
	logic [ANGLE_BITS-1:0] beam_q;
	logic [ANGLE_BITS-1:0] angle;
	logic                  accept;
	logic                  in_window;

	assign in_ready  = !q_stat.full;
	assign accept    = in_valid && in_ready;
	assign angle     = scan_begin ? angle_start_q : beam_q;
	assign in_window = (range_value >= range_low_q) && (range_value <= range_high_q);
	assign push      = accept && in_window;
	assign push_data = {range_value, angle};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_start_q <= '0;
			angle_step_q  <= '0;
			range_low_q   <= '0;
			range_high_q  <= '1;
			beam_q        <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ANGLE_START: angle_start_q <= cfg_data[ANGLE_BITS-1:0];
					CFG_ANGLE_STEP:  angle_step_q  <= cfg_data[ANGLE_BITS-1:0];
					CFG_RANGE_LOW:   range_low_q   <= cfg_data[RANGE_BITS-1:0];
					CFG_RANGE_HIGH:  range_high_q  <= cfg_data[RANGE_BITS-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				beam_q <= angle + angle_step_q;
			end
		end
	end

endmodule

// ===== design/s2c_sine.sv =====
module s2c_sine #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [ANGLE_BITS-1:0]         angle,
	output logic [s2c_pkg::MAG_W-1:0]     mag,
	output logic                          neg
);
	import s2c_pkg::*;

	localparam int QW = ANGLE_BITS - 2;
	localparam logic [QW:0]    QUARTER_T = (QW+1)'(1) << QW;
	localparam logic [QW+31:0] HALF_Q    = (QW+32)'(1) << (QW - 1);

	logic [QW:0]    t;
	logic [QW+31:0] xp;
	logic [30:0]    x_s1;
	logic [1:0]     q_s1;
	logic [61:0]    sq;
	logic [30:0]    x_s2;
	logic [31:0]    x2_s2;
	logic [1:0]     q_s2;

	// quadrant fold, then x = t * pi/2 scaled to 30 fraction bits
	assign t  = angle[QW] ? QUARTER_T - {1'b0, angle[QW-1:0]} : {1'b0, angle[QW-1:0]};
	assign xp = (QW+32)'(t) * (QW+32)'(PIH) + HALF_Q;
	assign sq = 62'(x_s1) * 62'(x_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= xp[QW+30:QW];
			q_s1  <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
			x_s2  <= x_s1;
			x2_s2 <= sq[61:30];
			q_s2  <= q_s1;
		end
	end

	logic [30:0] h_c  [N_TERMS];
	logic [30:0] x_c  [N_TERMS];
	logic [31:0] x2_c [N_TERMS];
	logic [1:0]  q_c  [N_TERMS];

	for (genvar i = 0; i < N_TERMS; i++) begin : g_term
		logic [30:0] h_in;
		logic [30:0] x_in;
		logic [31:0] x2_in;
		logic [1:0]  q_in;
		logic [62:0] pm;
		logic [63:0] rm;
		logic [31:0] rem;
		logic [29:0] qc;
		logic [31:0] p_sa;
		logic [30:0] x_sa;
		logic [31:0] x2_sa;
		logic [1:0]  q_sa;
		logic [31:0] p_sb;
		logic [29:0] qe_sb;
		logic [30:0] x_sb;
		logic [31:0] x2_sb;
		logic [1:0]  q_sb;

		if (i == 0) begin : g_first
			assign h_in  = FX_ONE;
			assign x_in  = x_s2;
			assign x2_in = x2_s2;
			assign q_in  = q_s2;
		end else begin : g_next
			assign h_in  = h_c[i-1];
			assign x_in  = x_c[i-1];
			assign x2_in = x2_c[i-1];
			assign q_in  = q_c[i-1];
		end

		assign pm  = 63'(x2_in) * 63'(h_in);
		assign rm  = 64'(p_sa) * 64'(RECIPS[i]);
		// estimate is low by at most one
		assign rem = p_sb - 32'(64'(qe_sb) * 64'(DIVS[i]));
		assign qc  = qe_sb + 30'(rem >= DIVS[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				p_sa    <= pm[61:30];
				x_sa    <= x_in;
				x2_sa   <= x2_in;
				q_sa    <= q_in;
				p_sb    <= p_sa;
				qe_sb   <= rm[61:32];
				x_sb    <= x_sa;
				x2_sb   <= x2_sa;
				q_sb    <= q_sa;
				h_c[i]  <= FX_ONE - 31'(qc);
				x_c[i]  <= x_sb;
				x2_c[i] <= x2_sb;
				q_c[i]  <= q_sb;
			end
		end
	end

	logic [61:0] sm;
	logic [31:0] s_sf;
	logic [1:0]  q_sf;
	logic [32:0] rnd;

	assign sm  = 62'(x_c[N_TERMS-1]) * 62'(h_c[N_TERMS-1]);
	assign rnd = {1'b0, s_sf} + 33'd8192;

	always_ff @(posedge clk) begin
		if (en) begin
			s_sf <= sm[61:30];
			q_sf <= q_c[N_TERMS-1];
			mag  <= rnd[MAG_W+13:14];
			neg  <= q_sf[1] && (rnd[MAG_W+13:14] != '0);
		end
	end

endmodule

// ===== design/s2c_back.sv =====
module s2c_back #(
	parameter int RANGE_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  s2c_pkg::q_stat_t                    q_stat,
	input  logic [RANGE_BITS+ANGLE_BITS-1:0]    head,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [RANGE_BITS:0]          point_x,
	output logic signed [RANGE_BITS:0]          point_y
);
	import s2c_pkg::*;

	localparam int LAST = SIN_LAT + 2;
	localparam int PW   = RANGE_BITS + MAG_W;
	localparam logic [ANGLE_BITS-1:0] QUARTER_A = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	logic                  en;
	logic [ANGLE_BITS-1:0] a_sin;
	logic [ANGLE_BITS-1:0] a_cos;
	logic [RANGE_BITS-1:0] r_in;
	logic [MAG_W-1:0]      cmag;
	logic [MAG_W-1:0]      smag;
	logic                  cneg;
	logic                  sneg;
	logic [PW-1:0]         xprod;
	logic [PW-1:0]         yprod;

	logic                  vld_s [1:LAST];
	logic [RANGE_BITS-1:0] rng_s [1:SIN_LAT];
	logic [RANGE_BITS-1:0] xm_s20;
	logic [RANGE_BITS-1:0] ym_s20;
	logic                  xn_s20;
	logic                  yn_s20;
	logic [RANGE_BITS:0]   px_s21;
	logic [RANGE_BITS:0]   py_s21;

	assign en    = !vld_s[LAST] || out_ready;
	assign pop   = !q_stat.empty && en;
	assign a_sin = head[ANGLE_BITS-1:0];
	assign r_in  = head[RANGE_BITS+ANGLE_BITS-1:ANGLE_BITS];
	assign a_cos = a_sin + QUARTER_A;

	s2c_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos (
		.clk   (clk),
		.en    (en),
		.angle (a_cos),
		.mag   (cmag),
		.neg   (cneg)
	);

	s2c_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin (
		.clk   (clk),
		.en    (en),
		.angle (a_sin),
		.mag   (smag),
		.neg   (sneg)
	);

	assign xprod = PW'(rng_s[SIN_LAT]) * PW'(cmag) + PW'(32768);
	assign yprod = PW'(rng_s[SIN_LAT]) * PW'(smag) + PW'(32768);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= pop;
			for (int k = 2; k <= LAST; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rng_s[1] <= r_in;
			for (int k = 2; k <= SIN_LAT; k++) begin
				rng_s[k] <= rng_s[k-1];
			end
			xm_s20 <= xprod[RANGE_BITS+15:16];
			ym_s20 <= yprod[RANGE_BITS+15:16];
			xn_s20 <= cneg;
			yn_s20 <= sneg;
			px_s21 <= xn_s20 ? -{1'b0, xm_s20} : {1'b0, xm_s20};
			py_s21 <= yn_s20 ? -{1'b0, ym_s20} : {1'b0, ym_s20};
		end
	end

	assign out_valid = vld_s[LAST];
	assign point_x   = px_s21;
	assign point_y   = py_s21;

endmodule

// ===== design/scan_polar_to_cartesian_unit.sv =====
// A beat passes the queue, the sine/cosine pipelines, then the product and sign registers.
// Throughput: one sample per cycle unless the queue fills; out-of-window samples produce no beat.
// The 19-stage sine/cosine pipelines (five-term Horner, <=1 multiply per stage) set the latency.
// Reset: configuration to defaults (range_high all ones), beam angle to zero,
// queue and pipeline valid flags cleared; no clearing pass.
module scan_polar_to_cartesian_unit #(
	parameter int RANGE_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [s2c_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [s2c_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [RANGE_BITS-1:0]               range_value,
	input  logic                                scan_begin,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [RANGE_BITS:0]          point_x,
	output logic signed [RANGE_BITS:0]          point_y
);
	import s2c_pkg::*;

	localparam int EW = RANGE_BITS + ANGLE_BITS;
	localparam logic [RANGE_BITS:0] PMIN = {1'b1, {RANGE_BITS{1'b0}}};

	q_stat_t       q_stat;
	logic          push;
	logic          pop;
	logic [EW-1:0] push_data;
	logic [EW-1:0] head;

	assign cfg_ready = 1'b1;

	s2c_front #(.RANGE_BITS(RANGE_BITS), .ANGLE_BITS(ANGLE_BITS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.range_value (range_value),
		.scan_begin  (scan_begin),
		.q_stat      (q_stat),
		.push        (push),
		.push_data   (push_data)
	);

	s2c_fifo #(.W(EW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.stat      (q_stat)
	);

	s2c_back #(.RANGE_BITS(RANGE_BITS), .ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.point_x   (point_x),
		.point_y   (point_y)
	);

	a_push_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> in_valid && in_ready)
		else $error("queue push without an input beat");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue pop while empty");

	a_point_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (point_x != PMIN) && (point_y != PMIN))
		else $error("point coordinate out of range");

endmodule
